>>> rtl/core/msrr_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and the CRC-16 byte step for the Modbus register responder.
// No dependencies; msrr_front, msrr_cmd_q, msrr_back and the top level import it.
package msrr_pkg;

  localparam int LEN_W = 9;   // frame length, up to 256 bytes held

  localparam logic [7:0] FC_READ  = 8'h03;
  localparam logic [7:0] FC_WRITE = 8'h10;
  localparam logic [7:0] EXC_FLAG = 8'h80;
  localparam logic [15:0] WR_MAX  = 16'd125;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  localparam logic [1:0] EXC_FUNC  = 2'd1;
  localparam logic [1:0] EXC_ADDR  = 2'd2;
  localparam logic [1:0] EXC_VALUE = 2'd3;

  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_READ = 1'b1;

  typedef enum logic [1:0] {
    ACT_BYTE = 2'd0,
    ACT_LWR  = 2'd1,
    ACT_LRD  = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    CMD_FRAME,
    CMD_LWR,
    CMD_LRD
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t          op;
    logic             in_range;
    logic [5:0]       addr;
    logic [15:0]      value;
    logic [LEN_W-1:0] len;
  } cmd_t;

  typedef struct packed {
    logic clearing;
    logic frame_done;
  } back_status_t;

  typedef enum logic [1:0] {
    MODE_EXC,
    MODE_READ,
    MODE_ECHO
  } tx_mode_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HDR,
    ST_DECIDE,
    ST_WR_A,
    ST_WR_B,
    ST_WR_C,
    ST_TX_BODY,
    ST_FETCH,
    ST_FETCH_W,
    ST_CRC_LO,
    ST_CRC_HI,
    ST_DONE,
    ST_LRD_W,
    ST_LRD_O
  } back_state_t;

  // CRC-16 Modbus, one byte (eight reflected shift steps)
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] data);
    logic [15:0] c;
    c = crc ^ {8'h00, data};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

>>> rtl/core/msrr_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for request items and result items.
// Depends on nothing but plain logic types.
interface msrr_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [7:0]  rx_byte;
  logic        frame_end;
  logic [5:0]  local_address;
  logic [15:0] local_value;

  modport source (output valid, action, rx_byte, frame_end, local_address, local_value,
                  input ready);
  modport sink   (input valid, action, rx_byte, frame_end, local_address, local_value,
                  output ready);
endinterface

interface msrr_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  tx_byte;
  logic        last;
  logic [15:0] read_value;

  modport source (output valid, kind, tx_byte, last, read_value, input ready);
  modport sink   (input valid, kind, tx_byte, last, read_value, output ready);
endinterface

>>> rtl/core/modbus_slave_register_responder.sv
`timescale 1ns / 1ps
// Top level of the Modbus RTU holding-register responder.
// Depends on msrr_pkg, msrr_if, msrr_ram, msrr_front, msrr_cmd_q and msrr_back.
//
// Usage notes:
//  - in_ch carries one transfer per request byte (action 0, frame_end on the
//    final byte), per local register write (action 1) or local read (action 2).
//  - out_ch carries response bytes in line order (kind 0, last on the CRC high
//    byte) and local read data (kind 1, last set).
//  - cfg_wr_en/cfg_wr_data load readonly_index; write it only while idle.
//  - After reset the register file is zeroed by a clearing pass over all
//    NUM_REGS registers; in_ch.ready stays low until it completes.
//  - Request bytes and local writes are accepted whenever in_ch.ready is high.
//    A local read is queued, read from the register file, then registered out.
//  - At a frame end the back end reads the 6 header bytes (ST_HDR), decides
//    (ST_DECIDE), for a write steps ST_WR_A, ST_WR_B, ST_WR_C per register, and
//    sends one byte per cycle while out_ch takes it, plus a fetch per read word.
//    The input stays stalled from frame end until the response is done.
//  - A stalled receiver holds the output register; the sequencer waits on it
//    and, through the two-entry command queue, the front end backs up too.
module modbus_slave_register_responder import msrr_pkg::*; #(
  parameter int NUM_REGS    = 64,
  parameter int MAX_READ    = 16,
  parameter int FRAME_DEPTH = 256
) (
  input  logic       clk,
  input  logic       rst_n,
  msrr_in_if.sink    in_ch,
  msrr_out_if.source out_ch,
  input  logic       cfg_wr_en,
  input  logic [5:0] cfg_wr_data
);
  localparam int FA_W = $clog2(FRAME_DEPTH);

  logic [5:0]      readonly_index_r;
  back_status_t    status;
  logic            q_push, q_ready, q_pop, q_valid;
  cmd_t            push_cmd, head_cmd;
  logic            fs_we;
  logic [FA_W-1:0] fs_waddr, fs_raddr;
  logic [7:0]      fs_wdata, fs_rdata;

  // single configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      readonly_index_r <= '0;
    end else if (cfg_wr_en) begin
      readonly_index_r <= cfg_wr_data;
    end
  end

  msrr_front #(.NUM_REGS(NUM_REGS), .FRAME_DEPTH(FRAME_DEPTH)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .status   (status),
    .q_ready  (q_ready),
    .q_push   (q_push),
    .q_cmd    (push_cmd),
    .fs_we    (fs_we),
    .fs_waddr (fs_waddr),
    .fs_wdata (fs_wdata)
  );

  // request frame store: written by the front end, read by the back end
  msrr_ram #(.WIDTH(8), .DEPTH(FRAME_DEPTH)) u_frame_store (
    .clk   (clk),
    .we    (fs_we),
    .waddr (fs_waddr),
    .wdata (fs_wdata),
    .raddr (fs_raddr),
    .rdata (fs_rdata)
  );

  msrr_cmd_q u_cmd_q (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .ready    (q_ready),
    .pop      (q_pop),
    .valid    (q_valid),
    .head     (head_cmd)
  );

  msrr_back #(.NUM_REGS(NUM_REGS), .MAX_READ(MAX_READ), .FRAME_DEPTH(FRAME_DEPTH)) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (q_valid),
    .q_cmd          (head_cmd),
    .q_pop          (q_pop),
    .readonly_index (readonly_index_r),
    .fs_raddr       (fs_raddr),
    .fs_rdata       (fs_rdata),
    .status         (status),
    .out_ch         (out_ch)
  );
endmodule

>>> rtl/core/msrr_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module msrr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> rtl/core/msrr_front.sv
`timescale 1ns / 1ps
// Front end: accepts input transfers, stores request bytes, queues commands.
// Depends on msrr_pkg and msrr_in_if.
module msrr_front import msrr_pkg::*; #(
  parameter int NUM_REGS    = 64,
  parameter int FRAME_DEPTH = 256
) (
  input  logic                           clk,
  input  logic                           rst_n,
  msrr_in_if.sink                        in_ch,
  input  back_status_t                   status,
  input  logic                           q_ready,
  output logic                           q_push,
  output cmd_t                           q_cmd,
  output logic                           fs_we,
  output logic [$clog2(FRAME_DEPTH)-1:0] fs_waddr,
  output logic [7:0]                     fs_wdata
);
  localparam int FA_W = $clog2(FRAME_DEPTH);

  logic             busy_r, busy_nxt;
  logic [LEN_W-1:0] flen_r, flen_nxt;
  logic             accept, flen_full, in_range;
  logic [LEN_W-1:0] flen_inc;

  assign in_ch.ready = !busy_r && !status.clearing && q_ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign flen_full   = flen_r >= LEN_W'(FRAME_DEPTH);
  assign flen_inc    = flen_full ? flen_r : flen_r + LEN_W'(1);
  assign in_range    = 32'(in_ch.local_address) < 32'(NUM_REGS);

  assign fs_waddr = FA_W'(flen_r);
  assign fs_wdata = in_ch.rx_byte;

  always_comb begin
    fs_we    = 1'b0;
    q_push   = 1'b0;
    flen_nxt = flen_r;
    busy_nxt = busy_r && !status.frame_done;
    q_cmd.op       = CMD_FRAME;
    q_cmd.in_range = in_range;
    q_cmd.addr     = in_ch.local_address;
    q_cmd.value    = in_ch.local_value;
    q_cmd.len      = flen_inc;
    if (accept) begin
      case (in_ch.action)
        ACT_BYTE: begin
          fs_we = !flen_full;
          if (in_ch.frame_end) begin
            q_push   = 1'b1;
            flen_nxt = '0;
            busy_nxt = 1'b1;
          end else begin
            flen_nxt = flen_inc;
          end
        end
        ACT_LWR: begin
          q_push   = 1'b1;
          q_cmd.op = CMD_LWR;
        end
        ACT_LRD: begin
          q_push   = 1'b1;
          q_cmd.op = CMD_LRD;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      flen_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      flen_r <= flen_nxt;
    end
  end
endmodule

>>> rtl/core/msrr_cmd_q.sv
`timescale 1ns / 1ps
// Two-entry command queue between front end and back end.
// Depends on msrr_pkg.
module msrr_cmd_q import msrr_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic ready,
  input  logic pop,
  output logic valid,
  output cmd_t head
);
  cmd_t       ent_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign ready = cnt_r != 2'd2;
  assign valid = cnt_r != 2'd0;
  assign head  = ent_r[rp_r];

  always_ff @(posedge clk) begin
    if (push && ready) begin
      ent_r[wp_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (push && ready) wp_r <= !wp_r;
      if (pop && valid)  rp_r <= !rp_r;
      cnt_r <= cnt_r + 2'(push && ready) - 2'(pop && valid);
    end
  end
endmodule

>>> rtl/core/msrr_back.sv
`timescale 1ns / 1ps
// Back end: decodes stored frames, owns the register file, builds responses with CRC.
// Depends on msrr_pkg, msrr_out_if and msrr_ram.
module msrr_back import msrr_pkg::*; #(
  parameter int NUM_REGS    = 64,
  parameter int MAX_READ    = 16,
  parameter int FRAME_DEPTH = 256
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           q_valid,
  input  cmd_t                           q_cmd,
  output logic                           q_pop,
  input  logic [5:0]                     readonly_index,
  output logic [$clog2(FRAME_DEPTH)-1:0] fs_raddr,
  input  logic [7:0]                     fs_rdata,
  output back_status_t                   status,
  msrr_out_if.source                     out_ch
);
  localparam int FA_W  = $clog2(FRAME_DEPTH);
  localparam int RI_W  = $clog2(NUM_REGS);
  localparam int TXL_W = $clog2(3 + 2 * MAX_READ + 1);

  back_state_t      state_r, state_nxt;
  logic [RI_W-1:0]  rptr_r, rptr_nxt;
  logic [LEN_W-1:0] ptr_r, ptr_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic [2:0]       hidx_r, hidx_nxt;
  logic [7:0]       hdr_r [6];
  logic [7:0]       hdr_nxt [6];
  logic [1:0]       code_r, code_nxt;
  tx_mode_t         mode_r, mode_nxt;
  logic [TXL_W-1:0] tx_idx_r, tx_idx_nxt;
  logic [TXL_W-1:0] tx_len_r, tx_len_nxt;
  logic [6:0]       wcnt_r, wcnt_nxt;
  logic [7:0]       hi_r, hi_nxt;
  logic [15:0]      word_r, word_nxt;
  logic [15:0]      crc_r, crc_nxt;
  logic             lrd_ok_r, lrd_ok_nxt;

  logic             ov_r, okind_r, olast_r;
  logic [7:0]       obyte_r;
  logic [15:0]      oval_r;

  logic             rf_we;
  logic [RI_W-1:0]  rf_waddr, rf_raddr;
  logic [15:0]      rf_wdata, rf_rdata;

  logic             emit_want, emit_fire, emit_kind, emit_last;
  logic [7:0]       emit_byte, body_byte;
  logic [15:0]      emit_value;

  logic [15:0]      first, count;
  logic [16:0]      lastidx;
  logic             addr_bad, ro_hit, rd_cnt_ok, wr_cnt_ok, wr_short;
  logic [TXL_W-1:0] tx_inc;

  msrr_ram #(.WIDTH(16), .DEPTH(NUM_REGS)) u_regfile (
    .clk   (clk),
    .we    (rf_we),
    .waddr (rf_waddr),
    .wdata (rf_wdata),
    .raddr (rf_raddr),
    .rdata (rf_rdata)
  );

  // header decode
  assign first     = {hdr_r[2], hdr_r[3]};
  assign count     = {hdr_r[4], hdr_r[5]};
  assign lastidx   = {1'b0, first} + {1'b0, count} - 17'd1;
  assign addr_bad  = lastidx >= 17'(NUM_REGS);
  assign ro_hit    = ({10'd0, readonly_index} >= first)
                  && ({11'd0, readonly_index} <= lastidx);
  assign rd_cnt_ok = (count != 16'd0) && (count <= 16'(MAX_READ));
  assign wr_cnt_ok = (count != 16'd0) && (count <= WR_MAX);
  assign wr_short  = {1'b0, len_r} < (10'd7 + (10'(count[7:0]) << 1));
  assign tx_inc    = tx_idx_r + TXL_W'(1);

  always_comb begin
    body_byte = 8'h00;
    case (mode_r)
      MODE_EXC: begin
        case (tx_idx_r)
          TXL_W'(0): body_byte = hdr_r[0];
          TXL_W'(1): body_byte = hdr_r[1] | EXC_FLAG;
          default:   body_byte = {6'd0, code_r};
        endcase
      end
      MODE_ECHO: body_byte = hdr_r[tx_idx_r[2:0]];
      MODE_READ: begin
        case (tx_idx_r)
          TXL_W'(0): body_byte = hdr_r[0];
          TXL_W'(1): body_byte = hdr_r[1];
          TXL_W'(2): body_byte = {count[6:0], 1'b0};
          default:   body_byte = tx_idx_r[0] ? word_r[15:8] : word_r[7:0];
        endcase
      end
      default: body_byte = 8'h00;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    q_pop             = 1'b0;
    fs_raddr          = FA_W'(ptr_r);
    rf_we             = 1'b0;
    rf_waddr          = rptr_r;
    rf_wdata          = 16'h0000;
    rf_raddr          = rptr_r;
    emit_want         = 1'b0;
    emit_kind         = KIND_BYTE;
    emit_byte         = 8'h00;
    emit_last         = 1'b0;
    emit_value        = 16'h0000;
    status.clearing   = state_r == ST_CLEAR;
    status.frame_done = 1'b0;
    case (state_r)
      ST_CLEAR: rf_we = 1'b1;
      ST_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          case (q_cmd.op)
            CMD_LWR: begin
              rf_we    = q_cmd.in_range;
              rf_waddr = RI_W'(q_cmd.addr);
              rf_wdata = q_cmd.value;
            end
            CMD_LRD: rf_raddr = RI_W'(q_cmd.addr);
            default: ;
          endcase
        end
      end
      ST_HDR:  fs_raddr = FA_W'(hidx_r);
      ST_WR_B: fs_raddr = FA_W'(ptr_r + LEN_W'(1));
      ST_WR_C: begin
        rf_we    = 1'b1;
        rf_wdata = {hi_r, fs_rdata};
      end
      ST_TX_BODY: begin
        emit_want = 1'b1;
        emit_byte = body_byte;
      end
      ST_CRC_LO: begin
        emit_want = 1'b1;
        emit_byte = crc_r[7:0];
      end
      ST_CRC_HI: begin
        emit_want = 1'b1;
        emit_byte = crc_r[15:8];
        emit_last = 1'b1;
      end
      ST_DONE: status.frame_done = 1'b1;
      ST_LRD_O: begin
        emit_want  = 1'b1;
        emit_kind  = KIND_READ;
        emit_last  = 1'b1;
        emit_value = word_r;
      end
      default: ;
    endcase
  end

  assign emit_fire = emit_want && (!ov_r || out_ch.ready);

  // next state and working registers
  always_comb begin
    state_nxt  = state_r;
    rptr_nxt   = rptr_r;
    ptr_nxt    = ptr_r;
    len_nxt    = len_r;
    hidx_nxt   = hidx_r;
    hdr_nxt    = hdr_r;
    code_nxt   = code_r;
    mode_nxt   = mode_r;
    tx_idx_nxt = tx_idx_r;
    tx_len_nxt = tx_len_r;
    wcnt_nxt   = wcnt_r;
    hi_nxt     = hi_r;
    word_nxt   = word_r;
    crc_nxt    = crc_r;
    lrd_ok_nxt = lrd_ok_r;
    case (state_r)
      ST_CLEAR: begin
        rptr_nxt = rptr_r + RI_W'(1);
        if (rptr_r == RI_W'(NUM_REGS - 1)) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (q_valid) begin
          case (q_cmd.op)
            CMD_FRAME: begin
              len_nxt   = q_cmd.len;
              hidx_nxt  = 3'd0;
              state_nxt = (q_cmd.len < LEN_W'(2)) ? ST_DONE : ST_HDR;
            end
            CMD_LRD: begin
              lrd_ok_nxt = q_cmd.in_range;
              state_nxt  = ST_LRD_W;
            end
            default: ;
          endcase
        end
      end
      ST_HDR: begin
        if (hidx_r != 3'd0) hdr_nxt[hidx_r - 3'd1] = fs_rdata;
        hidx_nxt = hidx_r + 3'd1;
        if (hidx_r == 3'd6) state_nxt = ST_DECIDE;
      end
      ST_DECIDE: begin
        crc_nxt    = CRC_INIT;
        tx_idx_nxt = '0;
        tx_len_nxt = TXL_W'(3);
        mode_nxt   = MODE_EXC;
        rptr_nxt   = RI_W'(first);
        ptr_nxt    = LEN_W'(7);
        wcnt_nxt   = count[6:0];
        state_nxt  = ST_TX_BODY;
        if (hdr_r[1] == FC_READ) begin
          if (len_r < LEN_W'(6)) begin
            state_nxt = ST_DONE;
          end else if (!rd_cnt_ok) begin
            code_nxt = EXC_VALUE;
          end else if (addr_bad) begin
            code_nxt = EXC_ADDR;
          end else begin
            mode_nxt   = MODE_READ;
            tx_len_nxt = TXL_W'(3) + (TXL_W'(count) << 1);
          end
        end else if (hdr_r[1] == FC_WRITE) begin
          if (len_r < LEN_W'(7)) begin
            state_nxt = ST_DONE;
          end else if (!wr_cnt_ok) begin
            code_nxt = EXC_VALUE;
          end else if (wr_short) begin
            state_nxt = ST_DONE;
          end else if (addr_bad) begin
            code_nxt = EXC_ADDR;
          end else if (ro_hit) begin
            code_nxt = EXC_FUNC;
          end else begin
            state_nxt = ST_WR_A;
          end
        end else begin
          code_nxt = EXC_FUNC;
        end
      end
      ST_WR_A: state_nxt = ST_WR_B;
      ST_WR_B: begin
        hi_nxt    = fs_rdata;
        state_nxt = ST_WR_C;
      end
      ST_WR_C: begin
        rptr_nxt = rptr_r + RI_W'(1);
        ptr_nxt  = ptr_r + LEN_W'(2);
        wcnt_nxt = wcnt_r - 7'd1;
        if (wcnt_r == 7'd1) begin
          mode_nxt   = MODE_ECHO;
          tx_len_nxt = TXL_W'(6);
          tx_idx_nxt = '0;
          state_nxt  = ST_TX_BODY;
        end else begin
          state_nxt = ST_WR_A;
        end
      end
      ST_TX_BODY: begin
        if (emit_fire) begin
          crc_nxt    = crc_byte(crc_r, body_byte);
          tx_idx_nxt = tx_inc;
          if (tx_inc == tx_len_r) begin
            state_nxt = ST_CRC_LO;
          end else if (mode_r == MODE_READ && tx_inc >= TXL_W'(3) && tx_inc[0]) begin
            state_nxt = ST_FETCH;
          end
        end
      end
      ST_FETCH: state_nxt = ST_FETCH_W;
      ST_FETCH_W: begin
        word_nxt  = rf_rdata;
        rptr_nxt  = rptr_r + RI_W'(1);
        state_nxt = ST_TX_BODY;
      end
      ST_CRC_LO: if (emit_fire) state_nxt = ST_CRC_HI;
      ST_CRC_HI: if (emit_fire) state_nxt = ST_DONE;
      ST_DONE:   state_nxt = ST_IDLE;
      ST_LRD_W: begin
        word_nxt  = lrd_ok_r ? rf_rdata : 16'h0000;
        state_nxt = ST_LRD_O;
      end
      ST_LRD_O:  if (emit_fire) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      rptr_r  <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rptr_r  <= rptr_nxt;
      if (emit_fire)         ov_r <= 1'b1;
      else if (out_ch.ready) ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r    <= ptr_nxt;
    len_r    <= len_nxt;
    hidx_r   <= hidx_nxt;
    hdr_r    <= hdr_nxt;
    code_r   <= code_nxt;
    mode_r   <= mode_nxt;
    tx_idx_r <= tx_idx_nxt;
    tx_len_r <= tx_len_nxt;
    wcnt_r   <= wcnt_nxt;
    hi_r     <= hi_nxt;
    word_r   <= word_nxt;
    crc_r    <= crc_nxt;
    lrd_ok_r <= lrd_ok_nxt;
    if (emit_fire) begin
      okind_r <= emit_kind;
      obyte_r <= emit_byte;
      olast_r <= emit_last;
      oval_r  <= emit_value;
    end
  end

  assign out_ch.valid      = ov_r;
  assign out_ch.kind       = okind_r;
  assign out_ch.tx_byte    = obyte_r;
  assign out_ch.last       = olast_r;
  assign out_ch.read_value = oval_r;

`ifndef SYNTHESIS
  a_read_data_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && okind_r == KIND_READ) |-> (olast_r && obyte_r == 8'h00))
    else $error("local read result malformed");

  a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) |-> (!ov_r && !q_pop))
    else $error("activity during register clear");

  a_tx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_TX_BODY) |-> (tx_idx_r < tx_len_r))
    else $error("response byte index overrun");

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE) |=> (state_r == ST_IDLE))
    else $error("frame completion not followed by idle");
`endif
endmodule

>>> tb/msrr_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the Modbus register responder: watches both channels and the
// config port, predicts the response stream and compares it. Needs msrr_pkg, msrr_if.
module msrr_checker import msrr_pkg::*; #(
  parameter int NUM_REGS    = 64,
  parameter int MAX_READ    = 16,
  parameter int FRAME_DEPTH = 256
) (
  input  logic       clk,
  input  logic       rst_n,
  msrr_in_if         in_mon,
  msrr_out_if        out_mon,
  input  logic       cfg_wr_en,
  input  logic [5:0] cfg_wr_data,
  output int         fail_count,
  output int         pending,
  output int         checked
);

  typedef struct packed {
    logic        kind;
    logic [7:0]  tx_byte;
    logic        last;
    logic [15:0] read_value;
  } result_t;

  result_t     expected_q[$];
  logic [7:0]  rx_frame[FRAME_DEPTH];
  int          rx_len;
  logic [15:0] holding_regs[NUM_REGS];
  logic [5:0]  ro_index;

  assign pending = expected_q.size();

  function automatic logic [15:0] modbus_crc(input logic [7:0] msg[0:39], input int n);
    logic [15:0] c;
    c = 16'hFFFF;
    for (int i = 0; i < n; i++) begin
      c = c ^ {8'h00, msg[i]};
      for (int k = 0; k < 8; k++) c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
    end
    return c;
  endfunction

  task automatic queue_response(input logic [7:0] msg[0:39], input int n);
    logic [15:0] c;
    c = modbus_crc(msg, n);
    msg[n] = c[7:0];
    msg[n+1] = c[15:8];
    for (int i = 0; i < n + 2; i++)
      expected_q.push_back('{KIND_BYTE, msg[i], i == n + 1, 16'h0000});
  endtask

  task automatic queue_exception(input logic [7:0] id, input logic [7:0] fc,
                                 input logic [1:0] code);
    logic [7:0] msg[0:39];
    msg[0] = id;
    msg[1] = fc | EXC_FLAG;
    msg[2] = {6'd0, code};
    queue_response(msg, 3);
  endtask

  // decode of a completed request frame
  task automatic decode_request();
    logic [7:0] msg[0:39];
    logic [7:0] id, fc;
    int first, count, lastidx;
    if (rx_len < 2) return;
    id = rx_frame[0];
    fc = rx_frame[1];
    if (fc == FC_READ) begin
      if (rx_len < 6) return;
      first = {rx_frame[2], rx_frame[3]};
      count = {rx_frame[4], rx_frame[5]};
      lastidx = first + count - 1;
      if (count < 1 || count > MAX_READ) queue_exception(id, fc, EXC_VALUE);
      else if (lastidx >= NUM_REGS) queue_exception(id, fc, EXC_ADDR);
      else begin
        msg[0] = id;
        msg[1] = fc;
        msg[2] = 8'(count * 2);
        for (int i = 0; i < count; i++) begin
          msg[3+2*i] = holding_regs[first+i][15:8];
          msg[4+2*i] = holding_regs[first+i][7:0];
        end
        queue_response(msg, 3 + 2 * count);
      end
    end else if (fc == FC_WRITE) begin
      if (rx_len < 7) return;
      first = {rx_frame[2], rx_frame[3]};
      count = {rx_frame[4], rx_frame[5]};
      lastidx = first + count - 1;
      if (count < 1 || count > int'(WR_MAX)) queue_exception(id, fc, EXC_VALUE);
      else if (rx_len < 7 + 2 * count) return;
      else if (lastidx >= NUM_REGS) queue_exception(id, fc, EXC_ADDR);
      else if (first <= ro_index && ro_index <= lastidx) queue_exception(id, fc, EXC_FUNC);
      else begin
        for (int i = 0; i < count; i++)
          holding_regs[first+i] = {rx_frame[7+2*i], rx_frame[8+2*i]};
        for (int i = 0; i < 6; i++) msg[i] = rx_frame[i];
        queue_response(msg, 6);
      end
    end else begin
      queue_exception(id, fc, EXC_FUNC);
    end
  endtask

  task automatic absorb_transfer();
    case (in_mon.action)
      ACT_BYTE: begin
        if (rx_len < FRAME_DEPTH) begin
          rx_frame[rx_len] = in_mon.rx_byte;
          rx_len++;
        end
        if (in_mon.frame_end) begin
          decode_request();
          rx_len = 0;
        end
      end
      ACT_LWR: if (in_mon.local_address < NUM_REGS)
        holding_regs[in_mon.local_address] = in_mon.local_value;
      ACT_LRD: expected_q.push_back('{KIND_READ, 8'h00, 1'b1,
          (in_mon.local_address < NUM_REGS) ? holding_regs[in_mon.local_address] : 16'h0});
      default: ;
    endcase
  endtask

  task automatic report(input string what, input logic [31:0] want, input logic [31:0] got);
    $display("%0t: mismatch on %s: expected %0h, got %0h", $time, what, want, got);
    fail_count++;
  endtask

  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      rx_len = 0;
      ro_index = '0;
      fail_count = 0;
      checked = 0;
      expected_q.delete();
      foreach (holding_regs[i]) holding_regs[i] = '0;
    end else begin
      if (cfg_wr_en) ro_index = cfg_wr_data;
      if (in_mon.valid && in_mon.ready) absorb_transfer();
      if (out_mon.valid && out_mon.ready) begin
        checked++;
        if (expected_q.size() == 0) begin
          report("unexpected transfer", 0, out_mon.tx_byte);
        end else begin
          want = expected_q.pop_front();
          if (out_mon.kind !== want.kind) report("kind", want.kind, out_mon.kind);
          if (out_mon.tx_byte !== want.tx_byte) report("tx_byte", want.tx_byte, out_mon.tx_byte);
          if (out_mon.last !== want.last) report("last", want.last, out_mon.last);
          if (out_mon.read_value !== want.read_value)
            report("read_value", want.read_value, out_mon.read_value);
        end
      end
    end
  end

endmodule

>>> tb/modbus_slave_register_responder_test.sv
`timescale 1ns / 1ps
// Stimulus and verdict for the Modbus register responder; the scoreboard sits
// in msrr_checker. Needs msrr_pkg, msrr_if, the block and msrr_checker.
module modbus_slave_register_responder_test;
  import msrr_pkg::*;

  // action code the block has no use for
  localparam logic [1:0] ACT_NONE = 2'd3;
  localparam int MAX_READ_TB = 16;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic       cfg_wr_en = 1'b0;
  logic [5:0] cfg_wr_data = '0;
  int fail_count, pending, checked;
  int sent = 0;
  int rx_hold = 0;        // cycles the receiver must still refuse
  logic [7:0] frame_q[$]; // request under construction

  msrr_in_if  in_ch();
  msrr_out_if out_ch();

  modbus_slave_register_responder dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  msrr_checker chk (
    .clk(clk), .rst_n(rst_n), .in_mon(in_ch), .out_mon(out_ch),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .fail_count(fail_count), .pending(pending), .checked(checked)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // mostly short gaps, now and then a long one
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // receiver: random stalls, or a forced hold-off while rx_hold runs down
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold > 0) begin
        out_ch.ready = 1'b0;
        rx_hold--;
      end else if (out_ch.ready && gap_len() != 0) begin
        out_ch.ready = 1'b0;
        repeat (gap_len()) begin
          @(negedge clk);
          if (rx_hold > 0) break;
        end
        out_ch.ready = 1'b1;
      end else begin
        out_ch.ready = 1'b1;
      end
    end
  end

  // one transfer; valid stays up across back-to-back items
  task automatic put(input logic [1:0] act, input logic [7:0] b, input logic fend,
                     input logic [5:0] addr, input logic [15:0] val);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_ch.valid = 1'b0;
      repeat (g) @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.action = act;
    in_ch.rx_byte = b;
    in_ch.frame_end = fend;
    in_ch.local_address = addr;
    in_ch.local_value = val;
    do @(posedge clk); while (!in_ch.ready);
    sent++;
    @(negedge clk);
  endtask

  task automatic local_op(input logic [1:0] act, input logic [5:0] addr,
                          input logic [15:0] val);
    put(act, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), addr, val);
  endtask

  // sends frame_q byte by byte, frame end on the final one
  task automatic send_request();
    foreach (frame_q[i])
      put(ACT_BYTE, frame_q[i], i == frame_q.size() - 1,
          6'($urandom_range(0, 63)), 16'($urandom_range(0, 65535)));
    frame_q.delete();
  endtask

  task automatic build_header(input logic [7:0] fc, input logic [15:0] first,
                              input logic [15:0] count);
    frame_q = '{8'($urandom_range(0, 255)), fc, first[15:8], first[7:0],
                count[15:8], count[7:0]};
  endtask

  task automatic add_crc_filler();
    frame_q.push_back(8'($urandom_range(0, 255)));
    frame_q.push_back(8'($urandom_range(0, 255)));
  endtask

  task automatic read_request(input int first, input int count);
    build_header(FC_READ, 16'(first), 16'(count));
    add_crc_filler();
    send_request();
  endtask

  task automatic write_request(input int first, input int count, input int words);
    build_header(FC_WRITE, 16'(first), 16'(count));
    frame_q.push_back(8'(count * 2));
    repeat (2 * words) frame_q.push_back(8'($urandom_range(0, 255)));
    add_crc_filler();
    send_request();
  endtask

  // wait until every predicted transfer has arrived, then let the back end settle
  task automatic drain();
    in_ch.valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic set_readonly(input logic [5:0] idx);
    drain();
    cfg_wr_en = 1'b1;
    cfg_wr_data = idx;
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  // well-formed traffic with random content, plus some noise
  task automatic random_traffic(input int items);
    int pick, first, count, n;
    while (sent < items) begin
      pick = $urandom_range(0, 99);
      first = $urandom_range(0, 63);
      if (pick < 30) begin
        count = $urandom_range(1, 4);
        if ($urandom_range(0, 9) == 0) count = $urandom_range(1, MAX_READ_TB);
        if (first + count > 64) first = 64 - count;
        read_request(first, count);
      end else if (pick < 50) begin
        count = $urandom_range(1, 4);
        if (first + count > 64) first = 64 - count;
        write_request(first, count, count);
      end else if (pick < 60) begin
        // broken: bad count, bad range or truncated data
        count = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 20);
        if ($urandom_range(0, 1)) read_request($urandom_range(50, 65535), count);
        else write_request(first, count, $urandom_range(0, 2));
      end else if (pick < 65) begin
        n = $urandom_range(1, 8);
        repeat (n) frame_q.push_back(8'($urandom_range(0, 255)));
        send_request();
      end else if (pick < 80) begin
        local_op(ACT_LWR, 6'($urandom_range(0, 63)), 16'($urandom_range(0, 65535)));
      end else if (pick < 97) begin
        local_op(ACT_LRD, 6'($urandom_range(0, 63)), 16'h0);
      end else begin
        local_op(ACT_NONE, 6'($urandom_range(0, 63)), 16'($urandom_range(0, 65535)));
      end
    end
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.action = ACT_BYTE;
    in_ch.rx_byte = '0;
    in_ch.frame_end = 1'b0;
    in_ch.local_address = '0;
    in_ch.local_value = '0;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;

    // directed: extremes, every function and exception, short frames
    local_op(ACT_LWR, 6'd0, 16'hFFFF);
    local_op(ACT_LWR, 6'd63, 16'h0000);
    local_op(ACT_LRD, 6'd0, 16'h0);
    local_op(ACT_LRD, 6'd63, 16'h0);
    read_request(0, 2);
    read_request(48, MAX_READ_TB);
    read_request(0, 0);
    read_request(0, MAX_READ_TB + 1);
    read_request(63, 2);
    read_request(16'hFFFF, 16'h0001);
    write_request(5, 1, 1);
    write_request(0, 2, 2);          // covers the read-only index
    write_request(0, 126, 0);
    write_request(63, 2, 2);
    write_request(10, 3, 2);         // data stops short
    build_header(8'h06, 0, 1);
    add_crc_filler();
    send_request();
    frame_q = '{8'h11};
    send_request();
    frame_q = '{8'h11, FC_READ, 8'h00, 8'h00, 8'h01};
    send_request();
    frame_q = '{8'h11, FC_WRITE, 8'h00, 8'h00, 8'h00, 8'h01};
    send_request();
    local_op(ACT_NONE, 6'd1, 16'hA5A5);

    set_readonly(6'd63);
    write_request(60, 4, 4);
    write_request(0, 4, 4);
    random_traffic(180);

    // receiver holds off while requests keep coming, so the input backs up
    drain();
    rx_hold = 400;
    read_request(0, MAX_READ_TB);
    read_request(16, MAX_READ_TB);
    local_op(ACT_LRD, 6'd20, 16'h0);

    set_readonly(6'($urandom_range(0, 63)));
    random_traffic(205);
    set_readonly(6'd0);
    random_traffic(218);
    drain();

    $display("covered %0d input transfers and %0d result transfers", sent, checked);
    $display("reads, writes, exceptions, short frames, local access, long receiver stall");
    if (fail_count == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

  initial begin
    #2000000;
    $display("timeout with %0d transfers still awaited", pending);
    $display("end of test: mismatches");
    $finish;
  end

endmodule

>>> sim.f
rtl/core/msrr_pkg.sv
rtl/core/msrr_if.sv
rtl/core/msrr_ram.sv
rtl/core/msrr_front.sv
rtl/core/msrr_cmd_q.sv
rtl/core/msrr_back.sv
rtl/core/modbus_slave_register_responder.sv
tb/msrr_checker.sv
tb/modbus_slave_register_responder_test.sv
